// ===== design/tfs_pkg.sv =====
// ----------------------------------------------------------------------------
// Telemetry frame stuffer package
// Shared widths, byte codes, the queued frame record and checksum helper.
// ----------------------------------------------------------------------------
package tfs_pkg;

    localparam int TYPE_ID_W       = 16;
    localparam int VALUE_W         = 32;
    localparam int BYTE_W          = 8;
    // Header, two type id bytes and four value bytes.
    localparam int N_RAW           = 7;
    localparam int IDX_W           = 3;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic FUNC_DATA  = 1'b0;
    localparam logic FUNC_EMPTY = 1'b1;

    localparam logic [BYTE_W-1:0] HDR_DATA  = 8'h10;
    localparam logic [BYTE_W-1:0] HDR_EMPTY = 8'h00;
    localparam logic [BYTE_W-1:0] ESC_BYTE  = 8'h7D;
    localparam logic [BYTE_W-1:0] FLAG_BYTE = 8'h7E;
    localparam logic [BYTE_W-1:0] ESC_XOR   = 8'h20;
    localparam logic [BYTE_W-1:0] CSUM_BASE = 8'hFF;

    typedef struct packed {
        logic [N_RAW-1:0]             esc;
        logic [N_RAW-1:0][BYTE_W-1:0] raw;
    } t_frame;

    // Eight-bit sum with the carry folded back into bit zero.
    function automatic logic [BYTE_W-1:0] eac_add(input logic [BYTE_W-1:0] a,
                                                  input logic [BYTE_W-1:0] b);
        logic [BYTE_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[BYTE_W-1:0] + {{(BYTE_W-1){1'b0}}, s[BYTE_W]};
    endfunction

endpackage

// ===== design/tfs_in_if.sv =====
// ----------------------------------------------------------------------------
// Frame request channel
// Valid/ready channel carrying one telemetry frame request per item.
// ----------------------------------------------------------------------------
interface tfs_in_if;
    logic                          valid;
    logic                          ready;
    logic                          func;
    logic [tfs_pkg::TYPE_ID_W-1:0] type_id;
    logic [tfs_pkg::VALUE_W-1:0]   value;

    modport source (output valid, func, type_id, value, input ready);
    modport sink   (input valid, func, type_id, value, output ready);
endinterface

// ===== design/tfs_out_if.sv =====
// ----------------------------------------------------------------------------
// Line byte channel
// Valid/ready channel carrying one stuffed line byte per item.
// ----------------------------------------------------------------------------
interface tfs_out_if;
    logic                       valid;
    logic                       ready;
    logic [tfs_pkg::BYTE_W-1:0] out_byte;
    logic                       last_byte;

    modport source (output valid, out_byte, last_byte, input ready);
    modport sink   (input valid, out_byte, last_byte, output ready);
endinterface

// ===== design/telemetry_frame_stuffer_core.sv =====
// ----------------------------------------------------------------------------
// Telemetry frame stuffer core
// Encodes telemetry frame requests into byte-stuffed serial line bytes.
// ----------------------------------------------------------------------------
// Usage:
// i_frame takes one frame request per item: func (data or empty frame),
// type_id and value. o_line gives one line byte per item, with last_byte set
// on the closing checksum byte of each frame.
// A frame gives 8 to 14 line bytes: seven frame bytes, each doubled when it
// must be escaped, and the checksum. The serialiser sends one byte per cycle
// while the receiver takes them; a request passes through the queue and then
// the output register before its first byte appears on the line.
// Requests are held in a queue of QUEUE_DEPTH frames, so new requests are
// taken while an earlier frame is still being sent, and while the last
// byte waits in the output register.
// When the receiver stalls the output byte holds and the serialiser waits;
// requests are taken until the queue is full.
// Reset empties the queue, drops any byte held on the line and clears the
// running checksum; the block accepts requests in the first cycle after it.
// ----------------------------------------------------------------------------
module telemetry_frame_stuffer_core #(
    parameter int QUEUE_DEPTH = tfs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tfs_in_if.sink    i_frame,
    tfs_out_if.source o_line
);
    import tfs_pkg::*;

    logic   q_full;
    logic   q_push;
    logic   q_pop;
    logic   q_valid;
    t_frame front_frame;
    t_frame head_frame;

    tfs_front u_front (
        .i_frame  (i_frame),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_frame  (front_frame)
    );

    tfs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_frame (front_frame),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_frame (head_frame)
    );

    tfs_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_frame (head_frame),
        .o_q_pop   (q_pop),
        .o_line    (o_line)
    );

endmodule

// ===== design/tfs_front.sv =====
// ----------------------------------------------------------------------------
// Frame stuffer front end
// Accepts frame requests, lays out the raw bytes and marks those to escape.
// ----------------------------------------------------------------------------
module tfs_front (
    tfs_in_if.sink          i_frame,
    input  logic            i_q_full,
    output logic            o_push,
    output tfs_pkg::t_frame o_frame
);
    import tfs_pkg::*;

    logic [VALUE_W-1:0] val;

    assign i_frame.ready = !i_q_full;
    assign o_push        = i_frame.valid && !i_q_full;

    // An empty frame sends zeros in place of the value.
    assign val = (i_frame.func == FUNC_EMPTY) ? '0 : i_frame.value;

    always_comb begin
        o_frame.raw[0] = (i_frame.func == FUNC_EMPTY) ? HDR_EMPTY : HDR_DATA;
        o_frame.raw[1] = i_frame.type_id[7:0];
        o_frame.raw[2] = i_frame.type_id[15:8];
        o_frame.raw[3] = val[7:0];
        o_frame.raw[4] = val[15:8];
        o_frame.raw[5] = val[23:16];
        o_frame.raw[6] = val[31:24];
        for (int i = 0; i < N_RAW; i++) begin
            o_frame.esc[i] = (o_frame.raw[i] == FLAG_BYTE) || (o_frame.raw[i] == ESC_BYTE);
        end
    end

endmodule

// ===== design/tfs_queue.sv =====
// ----------------------------------------------------------------------------
// Frame queue
// Short first-in first-out store of classified frames between front and back.
// ----------------------------------------------------------------------------
module tfs_queue #(
    parameter int DEPTH = tfs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tfs_pkg::t_frame i_frame,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output tfs_pkg::t_frame o_frame
);
    import tfs_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_frame           r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_frame = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_frame;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("frame queue count beyond depth");

    a_ptr_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wr_ptr == r_rd_ptr))
        else $error("empty frame queue with unequal pointers");

    a_full_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_full && !do_pop) |=> (r_count == FULL_CNT))
        else $error("full frame queue changed without a pop");
`endif

endmodule

// ===== design/tfs_back.sv =====
// ----------------------------------------------------------------------------
// Frame stuffer back end
// Serialises queued frames into stuffed line bytes and the closing checksum.
// ----------------------------------------------------------------------------
module tfs_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  tfs_pkg::t_frame i_q_frame,
    output logic            o_q_pop,
    tfs_out_if.source       o_line
);
    import tfs_pkg::*;

    localparam logic [IDX_W-1:0] CSUM_IDX = IDX_W'(N_RAW);

    logic [IDX_W-1:0]  r_idx, n_idx;
    logic              r_esc_phase, n_esc_phase;
    logic [BYTE_W-1:0] r_sum, n_sum;
    logic              r_out_valid, n_out_valid;
    logic [BYTE_W-1:0] r_out_byte, n_out_byte;
    logic              r_out_last, n_out_last;
    logic              advance;
    logic [BYTE_W-1:0] cur_raw;
    logic              cur_esc;

    assign advance = !r_out_valid || o_line.ready;

    always_comb begin
        cur_raw = '0;
        cur_esc = 1'b0;
        if (r_idx != CSUM_IDX) begin
            cur_raw = i_q_frame.raw[r_idx];
            cur_esc = i_q_frame.esc[r_idx];
        end
    end

    always_comb begin
        n_idx       = r_idx;
        n_esc_phase = r_esc_phase;
        n_sum       = r_sum;
        n_out_valid = r_out_valid && !o_line.ready;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        o_q_pop     = 1'b0;
        if (advance && i_q_valid) begin
            n_out_valid = 1'b1;
            if (r_idx == CSUM_IDX) begin
                // The checksum byte is sent as it is, never escaped.
                n_out_byte = CSUM_BASE - r_sum;
                n_out_last = 1'b1;
                n_idx      = '0;
                n_sum      = '0;
                o_q_pop    = 1'b1;
            end else if (cur_esc && !r_esc_phase) begin
                n_out_byte  = ESC_BYTE;
                n_out_last  = 1'b0;
                n_esc_phase = 1'b1;
            end else begin
                n_out_byte  = r_esc_phase ? (cur_raw ^ ESC_XOR) : cur_raw;
                n_out_last  = 1'b0;
                n_esc_phase = 1'b0;
                n_sum       = eac_add(r_sum, cur_raw);
                n_idx       = r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_esc_phase <= 1'b0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_idx       <= n_idx;
            r_esc_phase <= n_esc_phase;
            r_sum       <= n_sum;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
    end

    assign o_line.valid     = r_out_valid;
    assign o_line.out_byte  = r_out_byte;
    assign o_line.last_byte = r_out_last;

`ifndef SYNTHESIS
    a_esc_not_csum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_esc_phase |-> (r_idx != CSUM_IDX))
        else $error("escape pending on the checksum slot");

    a_esc_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_esc_phase |-> (r_out_valid && (r_out_byte == ESC_BYTE) && !r_out_last))
        else $error("escape pending without escape byte on the line");

    a_sum_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> ((r_sum == '0) && (r_idx == '0) && r_out_last))
        else $error("frame end did not clear the running sum");
`endif

endmodule
